// ===== rtl/ecc33_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc33_pkg
// Shared types and fixed-point constants for the ECC-33 received power core.
// ----------------------------------------------------------------------------
package ecc33_pkg;

	// signed Q16 dB quantity
	typedef logic signed [31:0] q16_t;

	// pipeline shape
	localparam int LOG_STAGES  = 4;
	localparam int PIPE_STAGES = 9;

	// field widths
	localparam int DIST_W  = 20;
	localparam int PWR_W   = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int LOG_IN_W  = 24;
	localparam int LOG_OUT_W = 19;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_MIN_DISTANCE = 3'd0,
		CFG_FREQUENCY    = 3'd1,
		CFG_TX_HEIGHT    = 3'd2,
		CFG_RX_HEIGHT    = 3'd3,
		CFG_MEDIUM_CITY  = 3'd4
	} cfg_idx_t;

	// log10(2) in Q30
	localparam logic [29:0] LOG10_2_Q30 = 30'd323228497;

	// model constants, Q16
	localparam q16_t C_AFS    = 32'sd6055526;
	localparam q16_t C_ABM    = 32'sd1337590;
	localparam q16_t C_ABM_D  = 32'sd644219;
	localparam q16_t C_ABM_F  = 32'sd517341;
	localparam q16_t C_ABM_FF = 32'sd626524;
	localparam q16_t C_GB_A   = 32'sd914751;  // includes the +1000 bias
	localparam q16_t C_GB_B   = 32'sd380109;
	localparam q16_t C_GR_A   = 32'sd2789868;
	localparam q16_t C_GR_B   = 32'sd897843;
	localparam q16_t C_GR_H   = 32'sd38339;
	localparam q16_t C_GR_OFF = 32'sd123994;
	localparam logic [15:0] C_GR_LIN = 16'd49742;
	// ceil(2^30 / 10), exact for numerators below 2^26
	localparam logic [26:0] RECIP_10 = 27'd107374183;

	// unit offsets: m to km, MHz to GHz, dm to m
	localparam q16_t OFS_DKM  = 32'sd275521;
	localparam q16_t OFS_FGHZ = 32'sd196608;
	localparam q16_t OFS_HB   = 32'sd216335;
	localparam q16_t OFS_HR   = 32'sd65536;

	// side information that travels with an item
	typedef struct packed {
		logic signed [PWR_W-1:0] tx;
		logic                    near;
		logic                    mode;
		logic [9:0]              rx_h;
	} side_t;

endpackage

// ===== rtl/ecc33_if.sv =====
// ----------------------------------------------------------------------------
// ecc33 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecc33_req_if;
	logic                               valid;
	logic                               ready;
	logic [ecc33_pkg::DIST_W-1:0]       distance_q4;
	logic signed [ecc33_pkg::PWR_W-1:0] tx_power_q8;

	modport source (output valid, output distance_q4, output tx_power_q8, input ready);
	modport sink   (input valid, input distance_q4, input tx_power_q8, output ready);
endinterface

interface ecc33_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [ecc33_pkg::PWR_W-1:0] rx_power_q8;
	logic                               inside_min_distance;

	modport source (output valid, output rx_power_q8, output inside_min_distance, input ready);
	modport sink   (input valid, input rx_power_q8, input inside_min_distance, output ready);
endinterface

// ===== rtl/ecc33_path_loss_core.sv =====
// ----------------------------------------------------------------------------
// ecc33_path_loss_core
// ECC-33 received power: tx power minus path loss, Q8.8 dBm, saturated.
// ----------------------------------------------------------------------------
// Pipeline: four log10 stages then five arithmetic stages, nine register stages in all.
// Throughput: one item per cycle while the response is not stalled.
// A stalled response holds only the stages behind it; bubbles still fill.
// Reset: valid bits clear, configuration registers take their defaults.
// ----------------------------------------------------------------------------
module ecc33_path_loss_core #(
	parameter int LOG_TABLE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ecc33_req_if.sink                         req,
	ecc33_rsp_if.source                       rsp,
	input  logic                              cfg_we,
	input  logic [ecc33_pkg::IDX_W-1:0]       cfg_index,
	input  logic [ecc33_pkg::CFG_W-1:0]       cfg_data
);

	localparam int N    = ecc33_pkg::PIPE_STAGES;
	localparam int L    = ecc33_pkg::LOG_STAGES;
	localparam int S_M1 = L;
	localparam int S_M2 = L + 1;
	localparam int S_M3 = L + 2;
	localparam int S_SUM = L + 3;
	localparam int S_OUT = L + 4;

	// signed Q16 product, rounded half away from zero
	function automatic ecc33_pkg::q16_t mulq(input ecc33_pkg::q16_t a, input ecc33_pkg::q16_t b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] pr;
		logic        neg;
		neg = a[31] ^ b[31];
		ma  = a[31] ? (~a + 32'd1) : a;
		mb  = b[31] ? (~b + 32'd1) : b;
		pr  = 64'(ma) * 64'(mb) + 64'd32768;
		mulq = neg ? -signed'(pr[47:16]) : signed'(pr[47:16]);
	endfunction

	// configuration registers
	logic [15:0] min_distance_q;
	logic [12:0] frequency_q;
	logic [13:0] tx_height_q;
	logic [9:0]  rx_height_q;
	logic        medium_city_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_distance_q <= 16'd20;
			frequency_q    <= 13'd2000;
			tx_height_q    <= 14'd500;
			rx_height_q    <= 10'd20;
			medium_city_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (ecc33_pkg::cfg_idx_t'(cfg_index))
				ecc33_pkg::CFG_MIN_DISTANCE: min_distance_q <= cfg_data;
				ecc33_pkg::CFG_FREQUENCY:    frequency_q    <= cfg_data[12:0];
				ecc33_pkg::CFG_TX_HEIGHT:    tx_height_q    <= cfg_data[13:0];
				ecc33_pkg::CFG_RX_HEIGHT:    rx_height_q    <= cfg_data[9:0];
				ecc33_pkg::CFG_MEDIUM_CITY:  medium_city_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or its successor moves
	logic [N-1:0]     valid_q;
	logic [N-1:0]     en;
	ecc33_pkg::side_t side_q [N];

	always_comb begin
		en[N-1] = !valid_q[N-1] || rsp.ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign req.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= req.valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	// side information shifts along with the valid bits
	ecc33_pkg::side_t side_in;

	always_comb begin
		side_in.tx   = req.tx_power_q8;
		side_in.near = req.distance_q4 <= {min_distance_q, 4'd0};
		side_in.mode = medium_city_q;
		side_in.rx_h = rx_height_q;
	end

	always_ff @(posedge clk) begin
		if (en[0]) side_q[0] <= side_in;
		for (int k = 1; k < N; k++) begin
			if (en[k]) side_q[k] <= side_q[k-1];
		end
	end

	// logarithms of distance, frequency and both heights
	logic [ecc33_pkg::LOG_OUT_W-1:0] yd;
	logic [ecc33_pkg::LOG_OUT_W-1:0] yf;
	logic [ecc33_pkg::LOG_OUT_W-1:0] yb;
	logic [ecc33_pkg::LOG_OUT_W-1:0] yr;

	ecc33_log10 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_d (
		.clk(clk), .en(en[L-1:0]), .x(24'(req.distance_q4)), .y(yd)
	);
	ecc33_log10 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_f (
		.clk(clk), .en(en[L-1:0]), .x(24'(frequency_q)), .y(yf)
	);
	ecc33_log10 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_b (
		.clk(clk), .en(en[L-1:0]), .x(24'(tx_height_q)), .y(yb)
	);
	ecc33_log10 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_r (
		.clk(clk), .en(en[L-1:0]), .x(24'(rx_height_q)), .y(yr)
	);

	// stage 5: unit offsets and first products
	ecc33_pkg::q16_t ld;
	ecc33_pkg::q16_t lf;
	ecc33_pkg::q16_t afs_s5;
	ecc33_pkg::q16_t abmd_s5;
	ecc33_pkg::q16_t abmf_s5;
	ecc33_pkg::q16_t lf2_s5;
	ecc33_pkg::q16_t ld2_s5;
	ecc33_pkg::q16_t grb_s5;
	ecc33_pkg::q16_t lh_s5;
	ecc33_pkg::q16_t lhr_s5;
	logic [25:0]     lin_s5;

	assign ld = signed'(32'(yd)) - ecc33_pkg::OFS_DKM;
	assign lf = signed'(32'(yf)) - ecc33_pkg::OFS_FGHZ;

	always_ff @(posedge clk) begin
		if (en[S_M1]) begin
			afs_s5  <= ecc33_pkg::C_AFS + 32'sd20 * ld + 32'sd20 * lf;
			abmd_s5 <= mulq(ecc33_pkg::C_ABM_D, ld);
			abmf_s5 <= mulq(ecc33_pkg::C_ABM_F, lf);
			lf2_s5  <= mulq(lf, lf);
			ld2_s5  <= mulq(ld, ld);
			grb_s5  <= mulq(ecc33_pkg::C_GR_B, lf);
			lh_s5   <= signed'(32'(yb)) - ecc33_pkg::OFS_HB;
			lhr_s5  <= signed'(32'(yr)) - ecc33_pkg::OFS_HR - ecc33_pkg::C_GR_H;
			lin_s5  <= 26'(side_q[S_M1-1].rx_h) * 26'(ecc33_pkg::C_GR_LIN) + 26'd5;
		end
	end

	// stage 6: second products and linear gain divide by ten
	ecc33_pkg::q16_t afs_s6;
	ecc33_pkg::q16_t abm_s6;
	ecc33_pkg::q16_t gbs_s6;
	ecc33_pkg::q16_t gra_s6;
	ecc33_pkg::q16_t lh_s6;
	ecc33_pkg::q16_t lhr_s6;
	logic [22:0]     linq_s6;
	logic [52:0]     lin_pr;

	assign lin_pr = 53'(lin_s5) * 53'(ecc33_pkg::RECIP_10);

	always_ff @(posedge clk) begin
		if (en[S_M2]) begin
			afs_s6  <= afs_s5;
			abm_s6  <= ecc33_pkg::C_ABM + abmd_s5 + abmf_s5 + mulq(ecc33_pkg::C_ABM_FF, lf2_s5);
			gbs_s6  <= ecc33_pkg::C_GB_A + mulq(ecc33_pkg::C_GB_B, ld2_s5);
			gra_s6  <= ecc33_pkg::C_GR_A + grb_s5;
			lh_s6   <= lh_s5;
			lhr_s6  <= lhr_s5;
			linq_s6 <= lin_pr[52:30];
		end
	end

	// stage 7: height gains
	ecc33_pkg::q16_t base_s7;
	ecc33_pkg::q16_t gb_s7;
	ecc33_pkg::q16_t grm_s7;
	ecc33_pkg::q16_t grl_s7;

	always_ff @(posedge clk) begin
		if (en[S_M3]) begin
			base_s7 <= afs_s6 + abm_s6;
			gb_s7   <= mulq(lh_s6, gbs_s6);
			grm_s7  <= mulq(gra_s6, lhr_s6);
			grl_s7  <= signed'(32'(linq_s6)) - ecc33_pkg::C_GR_OFF;
		end
	end

	// stage 8: total loss and received power in Q16
	ecc33_pkg::q16_t gr;
	ecc33_pkg::q16_t rx16_s8;

	assign gr = side_q[S_SUM-1].mode ? grm_s7 : grl_s7;

	always_ff @(posedge clk) begin
		if (en[S_SUM]) begin
			rx16_s8 <= ecc33_pkg::q16_t'(side_q[S_SUM-1].tx) * 32'sd256
				- (base_s7 - gb_s7 - gr);
		end
	end

	// stage 9: round to Q8.8, saturate, bypass inside minimum distance
	logic [31:0]                        rmag;
	logic [23:0]                        rm;
	logic signed [ecc33_pkg::PWR_W-1:0] rsat;
	logic signed [ecc33_pkg::PWR_W-1:0] rx_s9;

	always_comb begin
		rmag = rx16_s8[31] ? (~rx16_s8 + 32'd1) : rx16_s8;
		rm   = 24'((33'(rmag) + 33'd128) >> 8);
		if (rx16_s8[31]) begin
			rsat = (rm >= 24'd32768) ? -16'sd32768 : -signed'(rm[15:0]);
		end else begin
			rsat = (rm >= 24'd32767) ? 16'sd32767 : signed'(rm[15:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_OUT]) begin
			rx_s9 <= side_q[S_OUT-1].near ? side_q[S_OUT-1].tx : rsat;
		end
	end

	assign rsp.valid               = valid_q[N-1];
	assign rsp.rx_power_q8         = rx_s9;
	assign rsp.inside_min_distance = side_q[N-1].near;

endmodule

// ===== rtl/ecc33_log10.sv =====
// ----------------------------------------------------------------------------
// ecc33_log10
// Four-stage fixed-point log10 of a 24-bit integer, Q16 result.
// ----------------------------------------------------------------------------
module ecc33_log10 #(
	parameter int LOG_TABLE_DEPTH = 64
) (
	input  logic                                clk,
	input  logic [ecc33_pkg::LOG_STAGES-1:0]    en,
	input  logic [ecc33_pkg::LOG_IN_W-1:0]      x,
	output logic [ecc33_pkg::LOG_OUT_W-1:0]     y
);

	localparam int IDXW = $clog2(LOG_TABLE_DEPTH);
	localparam int TW   = $clog2(LOG_TABLE_DEPTH + 1);
	localparam int POSW = 24 + IDXW;

	// log2(1 + i/depth) in Q16, rounded to nearest
	function automatic logic [16:0] tab_entry(input int i);
		logic [63:0] m;
		logic [63:0] r;
		m = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
		r = '0;
		for (int b = 0; b < 20; b++) begin
			m = (m * m) >> 30;
			r = {r[62:0], 1'b0};
			if (m >= (64'd2 << 30)) begin
				r[0] = 1'b1;
				m = m >> 1;
			end
		end
		if (i == LOG_TABLE_DEPTH) begin
			tab_entry = 17'd65536;
		end else begin
			tab_entry = 17'((r + 64'd8) >> 4);
		end
	endfunction

	logic [16:0] log_tab [LOG_TABLE_DEPTH+1];

	for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_tab
		assign log_tab[g] = tab_entry(g);
	end

	// stage 1: leading one and normalized fraction
	logic [23:0] xn;
	logic [4:0]  p;
	logic [24:0] sh;
	logic [4:0]  p_s1;
	logic [23:0] f24_s1;

	always_comb begin
		xn = (x == '0) ? 24'd1 : x;
		p  = '0;
		for (int k = 0; k < 24; k++) begin
			if (xn[k]) p = 5'(k);
		end
		sh = {1'b0, xn} << (5'd24 - p);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1   <= p;
			f24_s1 <= sh[23:0];
		end
	end

	// stage 2: table position and lookup
	logic [POSW-1:0] pos;
	logic [IDXW-1:0] idx;
	logic [4:0]      p_s2;
	logic [16:0]     lo_s2;
	logic [16:0]     hi_s2;
	logic [23:0]     rem_s2;

	assign pos = POSW'(f24_s1) * POSW'(LOG_TABLE_DEPTH);
	assign idx = pos[POSW-1:24];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2   <= p_s1;
			lo_s2  <= log_tab[TW'(idx)];
			hi_s2  <= log_tab[TW'(idx) + TW'(1)];
			rem_s2 <= pos[23:0];
		end
	end

	// stage 3: interpolation, log2 in Q16
	logic [40:0] fr;
	logic [20:0] l2_s3;

	assign fr = 41'(hi_s2 - lo_s2) * 41'(rem_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			l2_s3 <= {p_s2, 16'd0} + 21'(lo_s2) + 21'(fr[40:24]);
		end
	end

	// stage 4: scale to log10, rounded
	logic [49:0] sc;
	logic [ecc33_pkg::LOG_OUT_W-1:0] y_s4;

	assign sc = 50'(l2_s3) * 50'(ecc33_pkg::LOG10_2_Q30) + (50'd1 << 29);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			y_s4 <= sc[48:30];
		end
	end

	assign y = y_s4;

endmodule

// ===== rtl/ecc33_chk.sv =====
// ----------------------------------------------------------------------------
// ecc33_chk
// Port-level checks for the ECC-33 core, bound to the top level.
// ----------------------------------------------------------------------------
module ecc33_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_rx_power_q8,
	input logic        rsp_inside_min_distance
);

	// nothing leaves while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	// an open output means the whole pipeline can move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ready || !rsp_valid) |-> req_ready)
		else $error("request stalled while output can drain");

	// a stalled response stays and holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_power_q8)
		&& $stable(rsp_inside_min_distance))
		else $error("stalled response changed");

endmodule

bind ecc33_path_loss_core ecc33_chk u_ecc33_chk (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.req_valid               (req.valid),
	.req_ready               (req.ready),
	.rsp_valid               (rsp.valid),
	.rsp_ready               (rsp.ready),
	.rsp_rx_power_q8         (rsp.rx_power_q8),
	.rsp_inside_min_distance (rsp.inside_min_distance)
);

// ===== tb/ecc33_checker.sv =====
// ----------------------------------------------------------------------------
// ecc33_checker
// Watches the configuration port and both channels of the ECC-33 core. Keeps
// a shadow of the registers, computes the expected received power for every
// request transfer and compares each response transfer with the oldest one.
// ----------------------------------------------------------------------------
module ecc33_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ecc33_req_if                        req,
	ecc33_rsp_if                        rsp,
	input  logic                        cfg_we,
	input  logic [ecc33_pkg::IDX_W-1:0] cfg_index,
	input  logic [ecc33_pkg::CFG_W-1:0] cfg_data,
	output int                          errors,
	output int                          outstanding
);

	// fixed-point model constants, Q16
	localparam longint K_AFS    = 6055526;
	localparam longint K_ABM    = 1337590;
	localparam longint K_ABM_D  = 644219;
	localparam longint K_ABM_F  = 517341;
	localparam longint K_ABM_FF = 626524;
	localparam longint K_GB_A   = 913751 + 1000;
	localparam longint K_GB_B   = 380109;
	localparam longint K_GR_A   = 2789868;
	localparam longint K_GR_B   = 897843;
	localparam longint K_GR_H   = 38339;
	localparam longint K_GR_LIN = 49742;
	localparam longint K_GR_OFF = 123994;
	localparam longint K_LOG2   = 323228497;
	localparam longint K_DKM    = 275521;
	localparam longint K_FGHZ   = 196608;
	localparam longint K_HB     = 216335;
	localparam longint K_HR     = 65536;

	typedef struct {
		logic signed [ecc33_pkg::PWR_W-1:0] rx_power;
		logic                               near;
	} rx_power_t;

	longint unsigned log2_frac [TABLE_DEPTH+1];
	rx_power_t       rx_expected [$];

	logic [15:0] min_dist_m;
	logic [12:0] freq_mhz;
	logic [13:0] tx_h_dm;
	logic [9:0]  rx_h_dm;
	logic        medium_city;

	// table of log2(1 + i/depth), Q16, by repeated squaring
	initial begin
		longint unsigned m, r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			m = ((longint'(TABLE_DEPTH) + i) << 30) / TABLE_DEPTH;
			r = 0;
			for (int b = 0; b < 20; b++) begin
				m = (m * m) >> 30;
				r = r << 1;
				if (m >= (64'd2 << 30)) begin
					r = r | 1;
					m = m >> 1;
				end
			end
			log2_frac[i] = (r + 8) >> 4;
		end
		log2_frac[TABLE_DEPTH] = 65536;
	end

	function automatic longint log10_q16(longint unsigned x);
		longint unsigned f24, pos, idx, rem, lo, hi, l2;
		int lead;
		x = x & 64'hFFFFFF;
		if (x == 0) x = 1;
		lead = 0;
		for (int k = 0; k < 24; k++) if (x[k]) lead = k;
		f24 = (x << (24 - lead)) - (64'd1 << 24);
		pos = f24 * TABLE_DEPTH;
		idx = pos >> 24;
		rem = pos & 64'hFFFFFF;
		if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
		lo = log2_frac[idx];
		hi = log2_frac[idx+1];
		l2 = longint'(lead) * 65536 + lo + (((hi - lo) * rem) >> 24);
		return longint'((l2 * K_LOG2 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic longint unsigned magnitude(longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	// Q16 product, half away from zero
	function automatic longint qmul(longint a, longint b);
		longint unsigned p;
		p = (magnitude(a) * magnitude(b) + 32768) >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic rx_power_t received_power(logic [ecc33_pkg::DIST_W-1:0] dist_q4,
			logic signed [ecc33_pkg::PWR_W-1:0] tx_q8);
		rx_power_t res;
		longint ld, lf, lh, afs, abm, gb, gr, rx16, rx8;
		longint unsigned m;
		if (longint'(dist_q4) <= longint'(min_dist_m) * 16) begin
			res.rx_power = tx_q8;
			res.near = 1'b1;
			return res;
		end
		ld = log10_q16(dist_q4) - K_DKM;
		lf = log10_q16(freq_mhz) - K_FGHZ;
		lh = log10_q16(tx_h_dm) - K_HB;
		afs = K_AFS + 20 * ld + 20 * lf;
		abm = K_ABM + qmul(K_ABM_D, ld) + qmul(K_ABM_F, lf) + qmul(K_ABM_FF, qmul(lf, lf));
		gb = qmul(lh, K_GB_A + qmul(K_GB_B, qmul(ld, ld)));
		if (medium_city)
			gr = qmul(K_GR_A + qmul(K_GR_B, lf), log10_q16(rx_h_dm) - K_HR - K_GR_H);
		else
			gr = (K_GR_LIN * longint'(rx_h_dm) + 5) / 10 - K_GR_OFF;
		rx16 = longint'(tx_q8) * 256 - (afs + abm - gb - gr);
		m = (magnitude(rx16) + 128) >> 8;
		if (m > 40000) m = 40000;
		rx8 = (rx16 < 0) ? -longint'(m) : longint'(m);
		if (rx8 > 32767) rx8 = 32767;
		if (rx8 < -32768) rx8 = -32768;
		res.rx_power = rx8[ecc33_pkg::PWR_W-1:0];
		res.near = 1'b0;
		return res;
	endfunction

	// register shadow, request prediction and response compare
	always @(posedge clk or negedge arst_n) begin
		rx_power_t want;
		int        fails;
		fails = 0;
		if (!arst_n) begin
			min_dist_m  <= 16'd20;
			freq_mhz    <= 13'd2000;
			tx_h_dm     <= 14'd500;
			rx_h_dm     <= 10'd20;
			medium_city <= 1'b0;
			errors      <= 0;
			rx_expected.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ecc33_pkg::CFG_MIN_DISTANCE: min_dist_m  <= cfg_data;
					ecc33_pkg::CFG_FREQUENCY:    freq_mhz    <= cfg_data[12:0];
					ecc33_pkg::CFG_TX_HEIGHT:    tx_h_dm     <= cfg_data[13:0];
					ecc33_pkg::CFG_RX_HEIGHT:    rx_h_dm     <= cfg_data[9:0];
					ecc33_pkg::CFG_MEDIUM_CITY:  medium_city <= cfg_data[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				rx_expected.push_back(received_power(req.distance_q4, req.tx_power_q8));
			if (rsp.valid && rsp.ready) begin
				if (rx_expected.size() == 0) begin
					$error("response transfer with nothing expected");
					fails++;
				end else begin
					want = rx_expected.pop_front();
					if (rsp.rx_power_q8 !== want.rx_power) begin
						$error("rx_power_q8: expected %0d, got %0d", want.rx_power,
							rsp.rx_power_q8);
						fails++;
					end
					if (rsp.inside_min_distance !== want.near) begin
						$error("inside_min_distance: expected %0b, got %0b", want.near,
							rsp.inside_min_distance);
						fails++;
					end
				end
			end
			errors      <= errors + fails;
			outstanding <= rx_expected.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the ECC-33 core through several register settings, extremes
// included, with directed and random link requests under varying handshake
// pressure; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 14;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [ecc33_pkg::IDX_W-1:0] cfg_index;
	logic [ecc33_pkg::CFG_W-1:0] cfg_data;
	int                          errors;
	int                          outstanding;
	int                          tx_idle_pct;
	int                          rx_idle_pct;
	bit                          hold_rsp;
	int                          items_sent;
	int                          settings_run;
	int                          quiet_cycles;

	ecc33_req_if req ();
	ecc33_rsp_if rsp ();

	ecc33_path_loss_core uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ecc33_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// response side: random stalls and the long hold-off
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (150) @(negedge clk);
				hold_rsp = 1'b0;
			end
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one request transfer; called at a falling edge, returns at one
	task automatic send_link(input logic [ecc33_pkg::DIST_W-1:0] dist_q4,
			input logic signed [ecc33_pkg::PWR_W-1:0] tx_q8);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.distance_q4 <= dist_q4;
		req.tx_power_q8 <= tx_q8;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// all five registers plus a write to an unused index
	task automatic load_setting(input logic [15:0] min_d, input logic [15:0] freq,
			input logic [15:0] tx_h, input logic [15:0] rx_h, input logic [15:0] mode);
		cfg_we <= 1'b1;
		cfg_index <= ecc33_pkg::CFG_MIN_DISTANCE; cfg_data <= min_d; @(negedge clk);
		cfg_index <= ecc33_pkg::CFG_FREQUENCY;    cfg_data <= freq;  @(negedge clk);
		cfg_index <= ecc33_pkg::CFG_TX_HEIGHT;    cfg_data <= tx_h;  @(negedge clk);
		cfg_index <= ecc33_pkg::CFG_RX_HEIGHT;    cfg_data <= rx_h;  @(negedge clk);
		cfg_index <= ecc33_pkg::CFG_MEDIUM_CITY;  cfg_data <= mode;  @(negedge clk);
		cfg_index <= ecc33_pkg::IDX_W'($urandom_range(5, 7));
		cfg_data <= 16'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_run++;
	endtask

	task automatic random_links(input int count, input int min_d);
		logic [ecc33_pkg::DIST_W-1:0] link_dist;
		int pick;
		for (int n = 0; n < count; n++) begin
			// idling pattern moves with the overall item count
			if (items_sent < 350) begin
				tx_idle_pct = 7; rx_idle_pct = 56;
			end else if (items_sent < 700) begin
				tx_idle_pct = 56; rx_idle_pct = 7;
			end else begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			pick = $urandom_range(9);
			if (pick < 4)
				link_dist = ecc33_pkg::DIST_W'($urandom);
			else if (pick < 8)
				link_dist = ecc33_pkg::DIST_W'($urandom) >> $urandom_range(19);
			else
				link_dist = ecc33_pkg::DIST_W'(min_d * 16 + $urandom_range(4) - 2);
			send_link(link_dist, ecc33_pkg::PWR_W'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.distance_q4 = '0;
		req.tx_power_q8 = '0;
		tx_idle_pct = 7;
		rx_idle_pct = 56;
		hold_rsp = 1'b0;
		items_sent = 0;
		settings_run = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed at reset values: threshold, zero distance, extremes
		send_link(20'd0, 16'sd0);
		send_link(20'd320, 16'sd32767);
		send_link(20'd321, -16'sd32768);
		send_link(20'hFFFFF, 16'sd32767);
		send_link(20'hFFFFF, -16'sd32768);
		send_link(20'd5000, 16'sd2560);
		send_link(20'd80000, -16'sd100);
		wait_idle();
		load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
		send_link(20'd0, 16'sd1234);
		send_link(20'd1, -16'sd32768);
		send_link(20'hFFFFF, 16'sd32767);
		send_link(20'h55555, 16'sh7F00);
		send_link(20'hAAAAA, -16'sd1);
		wait_idle();
		load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
		send_link(20'd1048560, 16'sd77);
		send_link(20'd1048561, -16'sd32768);
		send_link(20'hFFFFF, 16'sd32767);
		wait_idle();
		load_setting(16'd20, 16'd8000, 16'd10000, 16'd1000, 16'd1);
		send_link(20'd321, 16'sd0);
		send_link(20'hFFFFF, -16'sd32768);
		send_link(20'd16000, 16'sd5000);
		wait_idle();
		load_setting(16'd20, 16'd100, 16'd10, 16'd1, 16'd0);
		send_link(20'd321, 16'sd32767);
		send_link(20'hFFFFF, -16'sd32768);
		wait_idle();

		// random settings, each followed by a burst of random links
		for (int s = 0; s < 8; s++) begin
			int min_d;
			min_d = (s == 3) ? $urandom_range(65535) : $urandom_range(200);
			load_setting(16'(min_d), 16'($urandom_range(100, 8000)),
				16'($urandom_range(10, 10000)), 16'($urandom_range(1, 1000)),
				16'(s % 2));
			random_links(65, min_d);
			hold_rsp = 1'b1;
			random_links(65, min_d);
			wait_idle();
		end

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("ran %0d requests over %0d register settings", items_sent, settings_run);
		$display("both city modes, thresholds, zero and full-scale registers covered");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
